// ----- rtl/free_page_list_allocator_macros.svh -----
// -----------------------------------------------------------------------------
// free_page_list_allocator_macros
// Assertion macros shared by the allocator checks.
// -----------------------------------------------------------------------------
`ifndef FREE_PAGE_LIST_ALLOCATOR_MACROS_SVH
`define FREE_PAGE_LIST_ALLOCATOR_MACROS_SVH

// Same-cycle implication, off while reset is high
`define FPLA_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high
`define FPLA_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/fpla_pkg.sv -----
// -----------------------------------------------------------------------------
// fpla_pkg
// Types, sizes and codes of the free page list allocator.
// -----------------------------------------------------------------------------
package fpla_pkg;

   localparam int PAGE_W        = 10;
   localparam int COUNT_W       = PAGE_W + 1;
   localparam int STORE_DEPTH   = 1 << PAGE_W;
   localparam int INITIAL_PAGES = 256;
   localparam int MAX_PAGES     = 1024;
   localparam int PAGE_LIMIT    = (MAX_PAGES < STORE_DEPTH) ? MAX_PAGES : STORE_DEPTH;
   localparam int FORMAT_PAGES  = (INITIAL_PAGES > PAGE_LIMIT) ? PAGE_LIMIT : INITIAL_PAGES;

   localparam logic [1:0] OP_FORMAT = 2'd0;
   localparam logic [1:0] OP_ALLOC  = 2'd1;
   localparam logic [1:0] OP_FREE   = 2'd2;

   localparam logic [1:0] STS_OK          = 2'd0;
   localparam logic [1:0] STS_FULL        = 2'd1;
   localparam logic [1:0] STS_INVALID     = 2'd2;
   localparam logic [1:0] STS_UNFORMATTED = 2'd3;

   typedef struct packed {
      logic [1:0]        operation;
      logic [PAGE_W-1:0] page_number;
   } fpla_req_type;

   typedef struct packed {
      logic [PAGE_W-1:0] allocated_page;
      logic [1:0]        status;
   } fpla_rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic [PAGE_W-1:0] wr_addr;
      logic [PAGE_W-1:0] wr_data;
      logic [PAGE_W-1:0] rd_addr;
   } fpla_ram_cmd_type;

   typedef struct packed {
      logic         valid;
      fpla_rsp_type rsp;
   } fpla_done_type;

endpackage

// ----- rtl/fpla_ram.sv -----
// -----------------------------------------------------------------------------
// fpla_ram
// Single-port-write, single-port-read RAM with registered read data.
// -----------------------------------------------------------------------------
module fpla_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/fpla_seq.sv -----
// -----------------------------------------------------------------------------
// fpla_seq
// Sequencer: head and count registers, list pops and pushes, chain walks.
// -----------------------------------------------------------------------------
module fpla_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  fpla_pkg::fpla_req_type        req,
   output fpla_pkg::fpla_ram_cmd_type    ram_cmd,
   input  logic [fpla_pkg::PAGE_W-1:0]   rd_data,
   output fpla_pkg::fpla_done_type       done,
   output logic                          idle
);
   import fpla_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_RDWAIT = 2'd1;
   localparam logic [1:0] ST_CHAIN  = 2'd2;

   localparam logic [PAGE_W+1:0]  LIMIT_X   = (PAGE_W+2)'(PAGE_LIMIT);
   localparam logic [COUNT_W-1:0] INIT_CNT  = COUNT_W'(FORMAT_PAGES);
   localparam logic [PAGE_W-1:0]  INIT_LAST = PAGE_W'(FORMAT_PAGES - 1);
   localparam logic [PAGE_W-1:0]  FIRST_PG  = PAGE_W'(1);

   logic [1:0]         state_ff, state_in;
   logic [PAGE_W-1:0]  head_ff, head_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [PAGE_W-1:0]  idx_ff, idx_in;
   logic [PAGE_W-1:0]  last_ff, last_in;
   logic [PAGE_W-1:0]  page_ff, page_in;

   logic [PAGE_W+1:0]  dbl;
   logic               count_zero;
   logic               page_ok;
   logic               at_last;

   assign dbl        = {count_ff, 1'b0};
   assign count_zero = (count_ff == '0);
   assign page_ok    = (req.page_number != '0) && ({1'b0, req.page_number} < count_ff);
   assign at_last    = (idx_ff == last_ff);

   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      last_in  = last_ff;
      page_in  = page_ff;

      ram_cmd.wr_en   = 1'b0;
      ram_cmd.wr_addr = idx_ff;
      ram_cmd.wr_data = at_last ? '0 : idx_ff + PAGE_W'(1);
      ram_cmd.rd_addr = head_ff;

      done.valid              = 1'b0;
      done.rsp.allocated_page = '0;
      done.rsp.status         = STS_OK;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req.operation)
                  OP_FORMAT: begin
                     idx_in   = FIRST_PG;
                     last_in  = INIT_LAST;
                     head_in  = FIRST_PG;
                     count_in = INIT_CNT;
                     page_in  = '0;
                     state_in = ST_CHAIN;
                  end
                  OP_ALLOC: begin
                     priority if (count_zero) begin
                        done.valid      = 1'b1;
                        done.rsp.status = STS_UNFORMATTED;
                     end else if (head_ff != '0) begin
                        // read of mem[head] is already in flight
                        page_in  = head_ff;
                        state_in = ST_RDWAIT;
                     end else if (dbl > LIMIT_X) begin
                        done.valid      = 1'b1;
                        done.rsp.status = STS_FULL;
                     end else begin
                        // grow: chain count..2*count-1, hand out count
                        idx_in   = count_ff[PAGE_W-1:0];
                        last_in  = PAGE_W'(dbl - (PAGE_W+2)'(1));
                        head_in  = count_ff[PAGE_W-1:0] + PAGE_W'(1);
                        count_in = dbl[COUNT_W-1:0];
                        page_in  = count_ff[PAGE_W-1:0];
                        state_in = ST_CHAIN;
                     end
                  end
                  OP_FREE: begin
                     done.valid = 1'b1;
                     priority if (count_zero) begin
                        done.rsp.status = STS_UNFORMATTED;
                     end else if (!page_ok) begin
                        done.rsp.status = STS_INVALID;
                     end else begin
                        ram_cmd.wr_en   = 1'b1;
                        ram_cmd.wr_addr = req.page_number;
                        ram_cmd.wr_data = head_ff;
                        head_in         = req.page_number;
                     end
                  end
                  default: begin
                     done.valid = 1'b1;
                  end
               endcase
            end
         end
         ST_RDWAIT: begin
            head_in                 = rd_data;
            done.valid              = 1'b1;
            done.rsp.allocated_page = page_ff;
            state_in                = ST_IDLE;
         end
         ST_CHAIN: begin
            ram_cmd.wr_en = 1'b1;
            idx_in        = idx_ff + PAGE_W'(1);
            if (at_last) begin
               done.valid              = 1'b1;
               done.rsp.allocated_page = page_ff;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      last_ff <= last_in;
      page_ff <= page_in;
   end

   assign idle = (state_ff == ST_IDLE);

endmodule

// ----- rtl/free_page_list_allocator.sv -----
// -----------------------------------------------------------------------------
// free_page_list_allocator
// Free page list allocator over a 1024-entry next-pointer store.
// -----------------------------------------------------------------------------
// Requests enter on req_valid/req_data and are taken when req_stall is low;
// each request gives exactly one response on rsp_valid/rsp_data, in order.
// Free, bad requests and unused codes answer in the cycle after acceptance.
// Allocate from a non-empty list answers after the registered read of the
// next pointer at the head, then the head update, registered with the
// response. Format and an allocate that grows the store answer when the
// chain walk ends, writing one link a cycle through the single write port.
// One request is in flight at a time; a new one is taken while the previous
// response is being drained. Free requests can follow back to back, one a
// cycle, while the response is not stalled; an allocate from the list holds
// off the next request until its read of the next pointer is done.
// Reset clears the head, the page count (unformatted) and the response
// valid flag; the store itself is not cleared. A stalled response holds in
// the output register and further requests are stalled until it is taken.
// -----------------------------------------------------------------------------
module free_page_list_allocator (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  fpla_pkg::fpla_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output fpla_pkg::fpla_rsp_type rsp_data
);
   import fpla_pkg::*;

   fpla_ram_cmd_type   ram_cmd;
   fpla_done_type      done;
   logic [PAGE_W-1:0]  rd_data;
   logic               idle;
   logic               accept;

   logic               rsp_valid_ff, rsp_valid_in;
   fpla_rsp_type       rsp_data_ff, rsp_data_in;

   assign req_stall = !(idle && (!rsp_valid_ff || !rsp_stall));
   assign accept    = req_valid && !req_stall;

   fpla_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req_data),
      .ram_cmd (ram_cmd),
      .rd_data (rd_data),
      .done    (done),
      .idle    (idle)
   );

   fpla_ram #(
      .WIDTH (PAGE_W),
      .DEPTH (STORE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_cmd.wr_en),
      .wr_addr (ram_cmd.wr_addr),
      .wr_data (ram_cmd.wr_data),
      .rd_addr (ram_cmd.rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      priority if (done.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = done.rsp;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/fpla_checker.sv -----
// -----------------------------------------------------------------------------
// fpla_checker
// Port-level checks of the free page list allocator.
// -----------------------------------------------------------------------------
`include "free_page_list_allocator_macros.svh"

module fpla_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input fpla_pkg::fpla_rsp_type rsp_data
);
   import fpla_pkg::*;

   `FPLA_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled response changed")
   `FPLA_ASSERT_IMP(a_fail_no_page, rsp_valid && (rsp_data.status != STS_OK), rsp_data.allocated_page == '0, "failed request handed out a page")
   `FPLA_ASSERT_IMP(a_backpressure, rsp_valid && rsp_stall, req_stall, "request taken while response blocked")
   `FPLA_ASSERT_IMP(a_rsp_after_req, $rose(rsp_valid), $past(req_valid && !req_stall) || $past(req_stall), "response without a request")

endmodule

bind free_page_list_allocator fpla_checker u_fpla_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
